FILE: rtl/wavhdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared types and constants for the WAV header chunk parser.
// ----------------------------------------------------------------------------
package wavhdr_pkg;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam int unsigned MinFile     = 44;
  localparam int unsigned FmtMin      = 16;
  localparam int unsigned BodyFrom    = 12;
  localparam int unsigned RiffLastIdx = 3;
  localparam int unsigned BitsAt      = 14;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_TAG     = 3'd2,
    ST_OVERRUN     = 3'd3,
    ST_FMT_SHORT   = 3'd4,
    ST_UNSUPPORTED = 3'd5,
    ST_NO_FRAMES   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PH_RIFF = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_PAD  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        short_file;
    status_e     first_error;
    logic        in_body;
    logic [15:0] format_code;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] data_start;
    logic [31:0] data_length;
    logic        data_found;
  } summ_t;

endpackage

FILE: rtl/wavhdr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser channels
// Valid/ready channels for input bytes and parse results.
// ----------------------------------------------------------------------------
interface wavhdr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface wavhdr_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] channel_count;
  logic [31:0] rate_hz;
  logic [31:0] data_offset;
  logic [31:0] data_bytes;
  logic [30:0] frame_count;

  modport source (
    output valid, output status, output channel_count, output rate_hz,
    output data_offset, output data_bytes, output frame_count, input ready
  );
  modport sink (
    input valid, input status, input channel_count, input rate_hz,
    input data_offset, input data_bytes, input frame_count, output ready
  );
endinterface

FILE: rtl/wav_header_chunk_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header chunk parser
// Parses a byte stream of a WAV file and reports status and format fields.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle while the input side does not stall. A
// byte enters an input register and the chunk walker updates its state from
// it in the next cycle; a last byte waits there for a free result register,
// which it then loads and which offers the result. The input side stalls
// only when a last byte finds the result register full; the walker then
// restarts for the next file. The saturating byte counter is POSITION_BITS+1 bits.
module wav_header_chunk_parser_unit #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  wavhdr_byte_if.sink     item_i,
  wavhdr_result_if.source result_o
);
  import wavhdr_pkg::*;

  logic  fire;
  logic  out_free;
  item_t item;
  summ_t summ;

  wavhdr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .out_free_i (out_free),
    .fire_o     (fire),
    .item_o     (item)
  );

  wavhdr_walker #(
    .POSITION_BITS (POSITION_BITS)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .summ_o (summ)
  );

  wavhdr_result u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && item.last_byte),
    .summ_i     (summ),
    .out_free_o (out_free),
    .result_o   (result_o)
  );

endmodule

FILE: rtl/wavhdr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser input stage
// Registers one incoming item and releases it to the chunk walker.
// ----------------------------------------------------------------------------
module wavhdr_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  wavhdr_byte_if.sink          item_i,
  input  logic                 out_free_i,
  output logic                 fire_o,
  output wavhdr_pkg::item_t    item_o
);
  import wavhdr_pkg::*;

  logic  valid_q;
  item_t item_q;

  // hold a last byte until the result register can take it
  assign fire_o      = valid_q && (!item_q.last_byte || out_free_i);
  assign item_i.ready = !valid_q || fire_o;
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.ready) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      item_q.byte_value <= item_i.byte_value;
      item_q.last_byte  <= item_i.last_byte;
    end
  end

endmodule

FILE: rtl/wavhdr_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser chunk walker
// Tracks tags, chunk headers and bodies; captures fmt and data fields.
// ----------------------------------------------------------------------------
module wavhdr_walker #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  wavhdr_pkg::item_t    item_i,
  output wavhdr_pkg::summ_t    summ_o
);
  import wavhdr_pkg::*;

  localparam int unsigned PW = POSITION_BITS + 1;

  logic [PW-1:0] pos_q, pos_d;
  phase_e        phase_q, phase_d;
  logic [31:0]   tag_q, tag_d;
  logic [31:0]   clen_q, clen_d;
  logic [31:0]   crem_q, crem_d;
  logic [15:0]   fmt_q, fmt_d;
  logic [15:0]   chan_q, chan_d;
  logic [31:0]   rate_q, rate_d;
  logic [15:0]   bits_q, bits_d;
  logic [31:0]   dstart_q, dstart_d;
  logic [31:0]   dsize_q, dsize_d;
  logic          dfound_q, dfound_d;
  status_e       err_q, err_d;

  logic [31:0]    tag_sh;
  logic [2:0]     k;
  logic [31:0]    off;
  logic           done;
  logic [31:0]    done_tag;
  logic [31:0]    done_len;
  logic [PW+31:0] pos_ext;

  assign tag_sh  = {tag_q[23:0], item_i.byte_value};
  assign k       = crem_q[2:0];
  assign off     = clen_q - crem_q;
  assign pos_ext = {32'd0, pos_d};

  always_comb begin
    pos_d    = (pos_q == {PW{1'b1}}) ? pos_q : pos_q + {{(PW-1){1'b0}}, 1'b1};
    phase_d  = phase_q;
    tag_d    = tag_q;
    clen_d   = clen_q;
    crem_d   = crem_q;
    fmt_d    = fmt_q;
    chan_d   = chan_q;
    rate_d   = rate_q;
    bits_d   = bits_q;
    dstart_d = dstart_q;
    dsize_d  = dsize_q;
    dfound_d = dfound_q;
    err_d    = err_q;
    done     = 1'b0;
    done_tag = tag_q;
    done_len = clen_q;

    case (phase_q)
      PH_RIFF: begin
        tag_d = tag_sh;
        if (pos_q == PW'(RiffLastIdx) && tag_sh != TagRiff && err_q == ST_OK) begin
          err_d = ST_BAD_TAG;
        end
        if (pos_q == PW'(BodyFrom - 1)) begin
          if (tag_sh != TagWave && err_q == ST_OK) begin
            err_d = ST_BAD_TAG;
          end
          phase_d = PH_HDR;
          crem_d  = '0;
        end
      end
      PH_HDR: begin
        if (!k[2]) begin
          tag_d = tag_sh;
        end else begin
          if (k[1:0] == 2'd0) begin
            clen_d = '0;
          end
          clen_d[8*k[1:0] +: 8] = item_i.byte_value;
        end
        if (k == 3'd7) begin
          if (tag_q == TagData) begin
            dstart_d = pos_ext[31:0];
            dsize_d  = clen_d;
            dfound_d = 1'b1;
          end
          if (clen_d == '0) begin
            done     = 1'b1;
            done_len = clen_d;
          end else begin
            phase_d = PH_BODY;
            crem_d  = clen_d;
          end
        end else begin
          crem_d = {29'd0, k + 3'd1};
        end
      end
      PH_BODY: begin
        if (tag_q == TagFmt && clen_q >= 32'(FmtMin) && off[31:4] == '0) begin
          case (off[3:0]) inside
            [4'd0:4'd1]: fmt_d[8*off[0] +: 8] = item_i.byte_value;
            [4'd2:4'd3]: chan_d[8*off[0] +: 8] = item_i.byte_value;
            [4'd4:4'd7]: rate_d[8*off[1:0] +: 8] = item_i.byte_value;
            4'(BitsAt), 4'(BitsAt + 1): bits_d[8*off[0] +: 8] = item_i.byte_value;
            default: ;
          endcase
        end
        crem_d = crem_q - 32'd1;
        if (crem_d == '0) begin
          done = 1'b1;
        end
      end
      default: begin
        phase_d = PH_HDR;
        crem_d  = '0;
      end
    endcase

    if (done) begin
      if (done_tag == TagFmt && done_len < 32'(FmtMin) && err_d == ST_OK) begin
        err_d = ST_FMT_SHORT;
      end
      phase_d = done_len[0] ? PH_PAD : PH_HDR;
      crem_d  = '0;
    end
  end

  always_comb begin
    summ_o.short_file  = pos_d < PW'(MinFile);
    summ_o.first_error = err_d;
    summ_o.in_body     = phase_d == PH_BODY;
    summ_o.format_code = fmt_d;
    summ_o.channels    = chan_d;
    summ_o.rate        = rate_d;
    summ_o.bits        = bits_d;
    summ_o.data_start  = dstart_d;
    summ_o.data_length = dsize_d;
    summ_o.data_found  = dfound_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_RIFF;
      tag_q    <= '0;
      clen_q   <= '0;
      crem_q   <= '0;
      fmt_q    <= '0;
      chan_q   <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      dstart_q <= '0;
      dsize_q  <= '0;
      dfound_q <= 1'b0;
      err_q    <= ST_OK;
    end else if (fire_i) begin
      if (item_i.last_byte) begin
        pos_q    <= '0;
        phase_q  <= PH_RIFF;
        tag_q    <= '0;
        clen_q   <= '0;
        crem_q   <= '0;
        fmt_q    <= '0;
        chan_q   <= '0;
        rate_q   <= '0;
        bits_q   <= '0;
        dstart_q <= '0;
        dsize_q  <= '0;
        dfound_q <= 1'b0;
        err_q    <= ST_OK;
      end else begin
        pos_q    <= pos_d;
        phase_q  <= phase_d;
        tag_q    <= tag_d;
        clen_q   <= clen_d;
        crem_q   <= crem_d;
        fmt_q    <= fmt_d;
        chan_q   <= chan_d;
        rate_q   <= rate_d;
        bits_q   <= bits_d;
        dstart_q <= dstart_d;
        dsize_q  <= dsize_d;
        dfound_q <= dfound_d;
        err_q    <= err_d;
      end
    end
  end

  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HDR |-> crem_q[31:3] == '0)
    else $error("header byte count out of range");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> crem_q != '0)
    else $error("body phase with nothing left");

  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_byte |=> pos_q == '0 && phase_q == PH_RIFF)
    else $error("walker did not restart after last byte");

  a_pos_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last_byte |=> pos_q >= $past(pos_q) && pos_q != '0)
    else $error("byte position went backward");

endmodule

FILE: rtl/wavhdr_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser result stage
// Resolves the status on the last byte and holds the result item.
// ----------------------------------------------------------------------------
module wavhdr_result (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  wavhdr_pkg::summ_t    summ_i,
  output logic                 out_free_o,
  wavhdr_result_if.source      result_o
);
  import wavhdr_pkg::*;

  logic        valid_q;
  status_e     status_q, status_d;
  logic [15:0] chan_q;
  logic [31:0] rate_q;
  logic [31:0] doff_q;
  logic [31:0] dbytes_q;
  logic [30:0] frames_q, frames;
  logic        unsupported;

  assign frames = summ_i.channels[1] ? {1'b0, summ_i.data_length[31:2]} :
                                       summ_i.data_length[31:1];

  assign unsupported = summ_i.format_code != 16'd1 ||
                       (summ_i.channels != 16'd1 && summ_i.channels != 16'd2) ||
                       summ_i.bits != 16'd16 || !summ_i.data_found;

  always_comb begin
    if (summ_i.short_file) begin
      status_d = ST_SHORT;
    end else if (summ_i.first_error != ST_OK) begin
      status_d = summ_i.first_error;
    end else if (summ_i.in_body) begin
      status_d = ST_OVERRUN;
    end else if (unsupported) begin
      status_d = ST_UNSUPPORTED;
    end else if (frames == '0) begin
      status_d = ST_NO_FRAMES;
    end else begin
      status_d = ST_OK;
    end
  end

  assign out_free_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && load_i) begin
      status_q <= status_d;
      if (status_d == ST_OK) begin
        chan_q   <= summ_i.channels;
        rate_q   <= summ_i.rate;
        doff_q   <= summ_i.data_start;
        dbytes_q <= summ_i.data_length;
        frames_q <= frames;
      end else begin
        chan_q   <= '0;
        rate_q   <= '0;
        doff_q   <= '0;
        dbytes_q <= '0;
        frames_q <= '0;
      end
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.status        = status_q;
  assign result_o.channel_count = chan_q;
  assign result_o.rate_hz       = rate_q;
  assign result_o.data_offset   = doff_q;
  assign result_o.data_bytes    = dbytes_q;
  assign result_o.frame_count   = frames_q;

  a_ok_channels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q == ST_OK |-> chan_q == 16'd1 || chan_q == 16'd2)
    else $error("ok result with unsupported channel count");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q != ST_OK |-> chan_q == '0 && frames_q == '0 && dbytes_q == '0)
    else $error("error result carries nonzero fields");

endmodule
